@@ hdl/splc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splc_pkg
// Shared constants, codes and types of the sample player channel.
// ----------------------------------------------------------------------------
package splc_pkg;

  localparam int SAMPLE_DEPTH_DEF  = 65536;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 4;

  localparam int FUNC_W     = 3;
  localparam int ADDR_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 17;
  localparam int RATE_W     = 20;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_TRIGGER = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REWIND  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP    = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RESET = 20'd65536;

  typedef struct packed {
    logic tick;
    logic load;
    logic left_ok;
    logic right_ok;
    logic playing;
  } splc_ctl_t;

endpackage

@@ hdl/sample_player_lerp_channel_core.sv @@
// path: queue slot, then memory read, product and output registers
// throughput: one beat per cycle sustained while results do not stall; the
// memory stage reads both samples together from a dual-read sample memory
// a 4-entry command queue lets the input keep flowing while results stall
// reset: synchronous active-low; resets position, active flag, config,
// queue and pipeline valids; sample memory is not cleared
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_player_lerp_channel_core
// One sample playback channel with linear interpolation.
// ----------------------------------------------------------------------------
module sample_player_lerp_channel_core import splc_pkg::*; #(
  parameter int SAMPLE_DEPTH  = SAMPLE_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [FUNC_W-1:0]           in_func,
  input  logic [ADDR_W-1:0]           in_load_address,
  input  logic signed [SAMPLE_W-1:0]  in_load_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_sample_out,
  output logic                        out_playing
);

  localparam int MAW = $clog2(SAMPLE_DEPTH);
  localparam int QW  = $bits(splc_ctl_t) + 2 * MAW + FRACTION_BITS + SAMPLE_W;

  splc_ctl_t                f_ctl, b_ctl;
  logic [MAW-1:0]           f_raddr_l, f_raddr_r, b_raddr_l, b_raddr_r;
  logic [FRACTION_BITS-1:0] f_frac, b_frac;
  logic [SAMPLE_W-1:0]      f_wdata, b_wdata;
  logic [QW-1:0]            q_in, q_out;
  logic                     q_push_ready, q_pop_valid, q_pop_ready;
  logic                     accept;

  assign in_ready = q_push_ready;
  assign accept   = in_valid && q_push_ready;

  splc_front #(
    .SAMPLE_DEPTH  (SAMPLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .accept          (accept),
    .in_func         (in_func),
    .in_load_address (in_load_address),
    .in_load_value   (in_load_value),
    .ent_ctl         (f_ctl),
    .ent_raddr_l     (f_raddr_l),
    .ent_raddr_r     (f_raddr_r),
    .ent_frac        (f_frac),
    .ent_wdata       (f_wdata)
  );

  assign q_in = {f_ctl, f_raddr_l, f_raddr_r, f_frac, f_wdata};

  splc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (q_push_ready),
    .push_data  (q_in),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_out)
  );

  assign {b_ctl, b_raddr_l, b_raddr_r, b_frac, b_wdata} = q_out;

  splc_back #(
    .SAMPLE_DEPTH  (SAMPLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (q_pop_valid),
    .pop_ready      (q_pop_ready),
    .pop_ctl        (b_ctl),
    .pop_raddr_l    (b_raddr_l),
    .pop_raddr_r    (b_raddr_r),
    .pop_frac       (b_frac),
    .pop_wdata      (b_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_playing    (out_playing)
  );

endmodule

@@ hdl/splc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splc_front
// Config registers, play position and active flag; turns each beat into a
// back-end command with read addresses, fraction and range flags.
// ----------------------------------------------------------------------------
module splc_front import splc_pkg::*; #(
  parameter int SAMPLE_DEPTH  = SAMPLE_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int MAW = $clog2(SAMPLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                        accept,
  input  logic [FUNC_W-1:0]           in_func,
  input  logic [ADDR_W-1:0]           in_load_address,
  input  logic signed [SAMPLE_W-1:0]  in_load_value,
  output splc_ctl_t                   ent_ctl,
  output logic [MAW-1:0]              ent_raddr_l,
  output logic [MAW-1:0]              ent_raddr_r,
  output logic [FRACTION_BITS-1:0]    ent_frac,
  output logic [SAMPLE_W-1:0]         ent_wdata
);

  localparam int LW  = MAW + 1;
  localparam int LFW = LW + FRACTION_BITS;
  localparam int SW  = ((LFW > POS_W + 1) ? LFW : POS_W + 1) + 2;
  localparam int IW  = POS_W + 1;

  logic [LW-1:0]        len_r, len_sel, len_new;
  logic                 loop_r;
  logic [RATE_W-1:0]    rate_r, rate_sel;
  logic [LFW-1:0]       lenfix_sel;
  logic [SW-1:0]        pr1_r, pr1_nxt, pr2_r, pr2_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt, tick_pos;
  logic                 act_r, act_nxt, tick_act;
  logic [POS_W:0]       next_w;
  logic [SW-1:0]        d1, d2;
  logic [IW-1:0]        idx_w, idx1_w;
  logic                 load_hit;

  // config path, with end-of-sample offsets precomputed per write
  assign len_new = (32'(cfg_wdata[COUNT_W-1:0]) > 32'(SAMPLE_DEPTH)) ?
                   LW'(SAMPLE_DEPTH) : LW'(cfg_wdata[COUNT_W-1:0]);
  assign len_sel  = (cfg_we && cfg_index == CFG_SAMPLE_COUNT) ? len_new : len_r;
  assign rate_sel = (cfg_we && cfg_index == CFG_RATE_STEP) ?
                    cfg_wdata[RATE_W-1:0] : rate_r;
  assign lenfix_sel = LFW'(len_sel) << FRACTION_BITS;
  assign pr1_nxt = SW'(rate_sel) - SW'(lenfix_sel);
  assign pr2_nxt = SW'(rate_sel) - (SW'(lenfix_sel) << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      loop_r <= 1'b0;
      rate_r <= RATE_RESET;
      pr1_r  <= SW'(RATE_RESET);
      pr2_r  <= SW'(RATE_RESET);
    end else if (cfg_we) begin
      len_r  <= len_sel;
      rate_r <= rate_sel;
      pr1_r  <= pr1_nxt;
      pr2_r  <= pr2_nxt;
      if (cfg_index == CFG_LOOP_ENABLE) begin
        loop_r <= cfg_wdata[0];
      end
    end
  end

  // position advance
  assign next_w = {1'b0, pos_r} + (POS_W + 1)'(rate_r);
  assign d1     = SW'(pos_r) + pr1_r;
  assign d2     = SW'(pos_r) + pr2_r;

  always_comb begin
    tick_pos = next_w[POS_W-1:0];
    tick_act = 1'b1;
    if (!d1[SW-1]) begin
      if (loop_r) begin
        tick_pos = d2[SW-1] ? d1[POS_W-1:0] : '0;
      end else begin
        tick_act = 1'b0;
      end
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    act_nxt = act_r;
    unique case (in_func)
      FUNC_TICK: begin
        if (act_r) begin
          pos_nxt = tick_pos;
          act_nxt = tick_act;
        end
      end
      FUNC_TRIGGER: begin
        if (len_r != '0) begin
          act_nxt = 1'b1;
          pos_nxt = '0;
        end
      end
      FUNC_STOP: begin
        act_nxt = 1'b0;
      end
      FUNC_REWIND: begin
        act_nxt = 1'b0;
        pos_nxt = '0;
      end
      FUNC_LOAD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      act_r <= 1'b0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      act_r <= act_nxt;
    end
  end

  // command for the back end
  assign idx_w    = IW'(pos_r >> FRACTION_BITS);
  assign idx1_w   = idx_w + IW'(1);
  assign load_hit = 32'(in_load_address) < 32'(SAMPLE_DEPTH);

  always_comb begin
    ent_ctl.tick     = (in_func == FUNC_TICK) && act_r;
    ent_ctl.load     = (in_func == FUNC_LOAD) && load_hit;
    ent_ctl.left_ok  = idx_w < IW'(len_r);
    ent_ctl.right_ok = idx1_w < IW'(len_r);
    ent_ctl.playing  = act_nxt;
  end

  assign ent_raddr_l = (in_func == FUNC_LOAD) ? MAW'(in_load_address) : idx_w[MAW-1:0];
  assign ent_raddr_r = idx1_w[MAW-1:0];
  assign ent_frac    = pos_r[FRACTION_BITS-1:0];
  assign ent_wdata   = in_load_value;

endmodule

@@ hdl/splc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splc_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module splc_queue import splc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             push, pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

@@ hdl/splc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splc_back
// Sample memory, interpolation multiply and output register, three stages
// with per-stage stall.
// ----------------------------------------------------------------------------
module splc_back import splc_pkg::*; #(
  parameter int SAMPLE_DEPTH  = SAMPLE_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int MAW = $clog2(SAMPLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  splc_ctl_t                   pop_ctl,
  input  logic [MAW-1:0]              pop_raddr_l,
  input  logic [MAW-1:0]              pop_raddr_r,
  input  logic [FRACTION_BITS-1:0]    pop_frac,
  input  logic [SAMPLE_W-1:0]         pop_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_sample_out,
  output logic                        out_playing
);

  localparam int PRW = SAMPLE_W + FRACTION_BITS + 2;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) << (FRACTION_BITS - 1);

  logic [SAMPLE_W-1:0]        sample_mem_r [SAMPLE_DEPTH];
  logic                       take, m_adv, p_adv, o_adv;

  logic                       m_valid_r;
  splc_ctl_t                  m_ctl_r;
  logic [FRACTION_BITS-1:0]   m_frac_r;
  logic [SAMPLE_W-1:0]        rd_l_r, rd_r_r;

  logic                       p_valid_r;
  splc_ctl_t                  p_ctl_r;
  logic signed [SAMPLE_W:0]   p_left_r;
  logic signed [PRW-1:0]      p_prod_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_playing_r;

  logic signed [SAMPLE_W:0]        left_x, right_x, diff;
  logic signed [FRACTION_BITS:0]   frac_x;
  logic signed [PRW-1:0]           prod_nxt, sum, delta;
  logic signed [SAMPLE_W-1:0]      sample_nxt;

  assign o_adv     = !out_valid_r || out_ready;
  assign p_adv     = !p_valid_r || o_adv;
  assign m_adv     = !m_valid_r || p_adv;
  assign pop_ready = m_adv;
  assign take      = pop_valid && m_adv;

  // sample memory, loads and reads kept in beat order
  always_ff @(posedge clk) begin
    if (take && pop_ctl.load) begin
      sample_mem_r[pop_raddr_l] <= pop_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rd_l_r   <= sample_mem_r[pop_raddr_l];
      rd_r_r   <= sample_mem_r[pop_raddr_r];
      m_ctl_r  <= pop_ctl;
      m_frac_r <= pop_frac;
    end
  end

  // difference times fraction
  assign left_x   = m_ctl_r.left_ok  ? {rd_l_r[SAMPLE_W-1], rd_l_r} : '0;
  assign right_x  = m_ctl_r.right_ok ? {rd_r_r[SAMPLE_W-1], rd_r_r} : '0;
  assign diff     = right_x - left_x;
  assign frac_x   = {1'b0, m_frac_r};
  assign prod_nxt = PRW'(diff) * PRW'(frac_x);

  always_ff @(posedge clk) begin
    if (p_adv && m_valid_r) begin
      p_ctl_r  <= m_ctl_r;
      p_left_r <= left_x;
      p_prod_r <= prod_nxt;
    end
  end

  // round half up and add to left sample; zero for a non-tick beat
  assign sum        = p_prod_r + HALF;
  assign delta      = sum >>> FRACTION_BITS;
  assign sample_nxt = p_ctl_r.tick ? SAMPLE_W'(p_left_r + delta[SAMPLE_W:0]) : '0;

  always_ff @(posedge clk) begin
    if (o_adv && p_valid_r) begin
      out_sample_r  <= sample_nxt;
      out_playing_r <= p_ctl_r.playing;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (m_adv) begin
        m_valid_r <= pop_valid;
      end
      if (p_adv) begin
        p_valid_r <= m_valid_r;
      end
      if (o_adv) begin
        out_valid_r <= p_valid_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_playing    = out_playing_r;

endmodule

@@ hdl/splc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splc_checker
// Port-level checks of the sample player channel, bound to the top level.
// ----------------------------------------------------------------------------
module splc_checker import splc_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_sample_out,
  input logic                       out_playing
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out) && $stable(out_playing))
    else $error("result beat changed while stalled");

  // reset empties the queue and the pipeline
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("queue or pipeline not empty after reset");

  // a full queue only happens behind a stalled result
  a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked without a pending result");

  // a blocked input beat keeps the result side busy on the next cycle too
  a_block_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready && !out_ready |=> out_valid)
    else $error("result side idle while input blocked");

endmodule

bind sample_player_lerp_channel_core splc_checker u_splc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out),
  .out_playing    (out_playing)
);
